>>> src/gfd_pkg.sv
package gfd_pkg;

   localparam int COLOR_BITS = 16;
   localparam int CHANNELS = 3;
   localparam int PIXEL_BITS = 1 + CHANNELS * COLOR_BITS;
   localparam int DATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;

   localparam int WIDTH_BITS = 12;
   localparam int HEIGHT_BITS = 13;
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 12'd1024;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd1024;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 13;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_DRAIN = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int NEIGHBORS = 8;
   localparam int SUM_BITS = COLOR_BITS + 3;
   localparam int CNT_BITS = 4;
   localparam int RECIP_SHIFT = COLOR_BITS + 6;
   localparam int RECIP_BITS = RECIP_SHIFT + 1;
   localparam int PROD_BITS = SUM_BITS + RECIP_BITS;
   localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;

   // ceil(2^RECIP_SHIFT / n), indexed by neighbor count
   localparam logic [RECIP_BITS-1:0] RECIP [NEIGHBORS+1] = '{
      RECIP_BITS'(0),
      RECIP_BITS'(RECIP_ONE),
      RECIP_BITS'((RECIP_ONE + 1) / 2),
      RECIP_BITS'((RECIP_ONE + 2) / 3),
      RECIP_BITS'((RECIP_ONE + 3) / 4),
      RECIP_BITS'((RECIP_ONE + 4) / 5),
      RECIP_BITS'((RECIP_ONE + 5) / 6),
      RECIP_BITS'((RECIP_ONE + 6) / 7),
      RECIP_BITS'((RECIP_ONE + 7) / 8)
   };

   typedef logic [COLOR_BITS-1:0] color_type;

   typedef struct packed {
      logic filled;
      color_type [CHANNELS-1:0] rgb;
   } px_type;

   typedef struct packed {
      logic valid;
      px_type px;
   } cell_type;

   typedef struct packed {
      logic restart;
      logic [WIDTH_BITS-1:0] width;
      logic [HEIGHT_BITS-1:0] height;
   } cfg_type;

endpackage

>>> src/gutter_fill_dilation_pass.sv
// One 3x3 dilation pass over a raster-order RGB frame: a filled pixel passes
// unchanged, an empty pixel with filled neighbors inside the frame takes their
// rounded per-channel average and becomes filled. The block sustains one
// request per clock while the result port accepts; each pixel's result
// leaves frame_width + 1 pixels later, since the window center is read back
// from the middle-line buffer, and reaches the result port through the queue
// slot, line buffer read, window shift, neighbor sum, reciprocal multiply and
// output register. Both line buffers take one read and one write per cycle,
// which sets that rate. A four-entry queue sits between the request classifier
// and the filter pipeline and takes up to four requests while a result waits.
// After the last pixel of a frame, send frame_width + 1 drain ticks to flush
// the tail, or start the next frame. A write to frame_width or frame_height
// restarts the block and drops pending results.
module gutter_fill_dilation_pass #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [gfd_pkg::DATA_BITS-1:0] req_tdata, // in_red, in_green, in_blue, in_filled
   input  logic req_tuser,                          // action
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [gfd_pkg::DATA_BITS-1:0] rsp_tdata, // out_red, out_green, out_blue, out_filled
   output logic rsp_tlast,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [gfd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gfd_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import gfd_pkg::*;

   logic [WIDTH_BITS-1:0] width_ff, width_in, width_eff;
   logic [HEIGHT_BITS-1:0] height_ff, height_in, height_eff;
   logic csr_hit;
   cfg_type cfg;
   logic q_push, q_full, q_pop, q_valid;
   cell_type q_in_data, q_out_data;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      csr_hit = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_in = csr_wdata[WIDTH_BITS-1:0];
               csr_hit = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = csr_wdata[HEIGHT_BITS-1:0];
               csr_hit = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      width_eff = width_ff;
      if (width_ff == '0) begin
         width_eff = WIDTH_BITS'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         width_eff = WIDTH_BITS'(MAX_WIDTH);
      end
      height_eff = height_ff;
      if (height_ff == '0) begin
         height_eff = HEIGHT_BITS'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         height_eff = HEIGHT_BITS'(MAX_HEIGHT);
      end
   end

   assign cfg = {csr_hit, width_eff, height_eff};

   gfd_front #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .q_full(q_full),
      .q_push(q_push),
      .q_data(q_in_data)
   );

   gfd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .flush(cfg.restart),
      .push(q_push),
      .push_data(q_in_data),
      .full(q_full),
      .pop(q_pop),
      .valid(q_valid),
      .data(q_out_data)
   );

   gfd_back #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .q_valid(q_valid),
      .q_data(q_out_data),
      .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_restart_clears_output: assert property (@(posedge clock) disable iff (reset)
      cfg.restart |=> !rsp_tvalid)
      else $error("result still valid after restart");

   a_restart_clears_queue: assert property (@(posedge clock) disable iff (reset)
      cfg.restart |=> !q_valid)
      else $error("queue not empty after restart");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("request pushed into full queue");
`endif

endmodule

>>> src/gfd_front.sv
module gfd_front #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic clock,
   input  logic reset,
   input  gfd_pkg::cfg_type cfg,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [gfd_pkg::DATA_BITS-1:0] req_tdata,
   input  logic req_tuser,
   input  logic q_full,
   output logic q_push,
   output gfd_pkg::cell_type q_data
);
   import gfd_pkg::*;

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int RB = $clog2(MAX_HEIGHT);
   localparam int DB = $clog2(MAX_WIDTH + 2);
   localparam int XA = (DB > CB + 1) ? DB : CB + 1;
   localparam int XW = (XA > WIDTH_BITS) ? XA : WIDTH_BITS;
   localparam int YW = (RB + 1 > HEIGHT_BITS) ? RB + 1 : HEIGHT_BITS;

   logic [CB-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;
   logic [DB-1:0] drain_ff, drain_in;
   logic primed_ff, primed_in;
   logic accept, at_start, drain_ok, col_last, row_last;
   px_type px;

   assign req_tready = !q_full;
   assign accept = req_tvalid && !q_full;
   assign px = px_type'(req_tdata[PIXEL_BITS-1:0]);
   assign at_start = (col_ff == '0) && (row_ff == '0);
   assign drain_ok = at_start && primed_ff && (XW'(drain_ff) <= XW'(cfg.width));
   assign col_last = (XW'(col_ff) + XW'(1)) >= XW'(cfg.width);
   assign row_last = (YW'(row_ff) + YW'(1)) >= YW'(cfg.height);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      drain_in = drain_ff;
      primed_in = primed_ff;
      q_push = 1'b0;
      q_data = '0;
      if (accept) begin
         unique case (req_tuser)
            ACTION_PIXEL: begin
               q_push = 1'b1;
               q_data.valid = 1'b1;
               q_data.px = px;
               primed_in = 1'b1;
               drain_in = '0;
               if (col_last) begin
                  col_in = '0;
                  row_in = row_last ? '0 : row_ff + RB'(1);
               end else begin
                  col_in = col_ff + CB'(1);
               end
            end
            ACTION_DRAIN: begin
               if (drain_ok) begin
                  q_push = 1'b1;
                  drain_in = drain_ff + DB'(1);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         col_ff <= '0;
         row_ff <= '0;
         drain_ff <= '0;
         primed_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         drain_ff <= drain_in;
         primed_ff <= primed_in;
      end
   end

endmodule

>>> src/gfd_queue.sv
module gfd_queue (
   input  logic clock,
   input  logic reset,
   input  logic flush,
   input  logic push,
   input  gfd_pkg::cell_type push_data,
   output logic full,
   input  logic pop,
   output logic valid,
   output gfd_pkg::cell_type data
);
   import gfd_pkg::*;

   cell_type slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign data = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && valid;

   always_comb begin
      wr_in = do_push ? wr_ff + QUEUE_PTR_BITS'(1) : wr_ff;
      rd_in = do_pop ? rd_ff + QUEUE_PTR_BITS'(1) : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> src/gfd_back.sv
module gfd_back #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic clock,
   input  logic reset,
   input  gfd_pkg::cfg_type cfg,
   input  logic q_valid,
   input  gfd_pkg::cell_type q_data,
   output logic q_pop,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [gfd_pkg::DATA_BITS-1:0] rsp_tdata,
   output logic rsp_tlast
);
   import gfd_pkg::*;

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int RB = $clog2(MAX_HEIGHT);
   localparam int FB = CB + 1;
   localparam int XW = (CB + 1 > WIDTH_BITS) ? CB + 1 : WIDTH_BITS;
   localparam int YW = (RB + 1 > HEIGHT_BITS) ? RB + 1 : HEIGHT_BITS;

   cell_type mid_mem [MAX_WIDTH];
   px_type up_mem [MAX_WIDTH];

   logic adv, pop, fill_ok, a_last;

   logic [CB-1:0] a_ff, a_in;
   logic [FB-1:0] fill_ff, fill_in;

   cell_type mid_rd_ff;
   px_type up_rd_ff;
   logic vb_ff, vb_in;
   logic [CB-1:0] ab_ff;
   px_type sb_ff;
   logic fok_b_ff;
   logic fwd_ff, fwd_in;
   px_type fwd_px_ff;
   px_type up_b;

   px_type win_ff [3][3];
   px_type win_in [3][3];
   logic [1:0] wv_ff, wv_in;
   logic vc_ff, vc_in;

   logic [CB-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;
   px_type center;
   px_type nb [NEIGHBORS];
   logic [NEIGHBORS-1:0] nb_ok;
   logic top_ok, bot_ok, left_ok, right_ok, emit, end_c;
   logic [CHANNELS-1:0][SUM_BITS-1:0] sum_c;
   logic [CNT_BITS-1:0] cnt_c;

   logic vd_ff, vd_in;
   logic [CHANNELS-1:0][SUM_BITS-1:0] sum_d_ff;
   logic [CNT_BITS-1:0] cnt_d_ff;
   px_type ctr_d_ff;
   logic end_d_ff;

   logic [CHANNELS-1:0][PROD_BITS-1:0] prod_in;
   logic ve_ff, ve_in;
   logic [CHANNELS-1:0][PROD_BITS-1:0] prod_e_ff;
   logic [CNT_BITS-1:0] cnt_e_ff;
   px_type ctr_e_ff;
   logic end_e_ff;

   px_type res_e;
   logic out_v_ff, out_v_in;
   px_type out_px_ff;
   logic out_end_ff;

   assign adv = !out_v_ff || rsp_tready;
   assign pop = adv && q_valid;
   assign q_pop = pop;

   // line buffers
   assign fill_ok = XW'(fill_ff) >= XW'(cfg.width);
   assign a_last = (XW'(a_ff) + XW'(1)) >= XW'(cfg.width);

   always_comb begin
      a_in = a_ff;
      fill_in = fill_ff;
      if (pop) begin
         a_in = a_last ? '0 : a_ff + CB'(1);
         if (!fill_ok) begin
            fill_in = fill_ff + FB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mid_rd_ff <= mid_mem[a_ff];
         up_rd_ff <= up_mem[a_ff];
      end
      if (pop) begin
         mid_mem[a_ff] <= q_data;
      end
      if (adv && vb_ff) begin
         up_mem[ab_ff] <= mid_rd_ff.px;
      end
   end

   assign vb_in = adv ? pop : vb_ff;
   assign fwd_in = adv ? (vb_ff && pop && (ab_ff == a_ff)) : fwd_ff;
   assign up_b = fwd_ff ? fwd_px_ff : up_rd_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ab_ff <= a_ff;
         sb_ff <= q_data.px;
         fok_b_ff <= fill_ok;
         fwd_px_ff <= mid_rd_ff.px;
      end
   end

   // window
   always_comb begin
      win_in = win_ff;
      wv_in = wv_ff;
      vc_in = adv ? vb_ff : vc_ff;
      if (adv && vb_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][2] = win_ff[r][1];
            win_in[r][1] = win_ff[r][0];
         end
         win_in[0][0] = up_b;
         win_in[1][0] = mid_rd_ff.px;
         win_in[2][0] = sb_ff;
         wv_in[0] = mid_rd_ff.valid && fok_b_ff;
         wv_in[1] = wv_ff[0];
      end
   end

   // neighbor sum
   assign center = win_ff[1][1];
   assign emit = vc_ff && wv_ff[1];
   assign top_ok = (row_ff != '0);
   assign bot_ok = (YW'(row_ff) + YW'(1)) < YW'(cfg.height);
   assign left_ok = (col_ff != '0);
   assign right_ok = (XW'(col_ff) + XW'(1)) < XW'(cfg.width);
   assign end_c = ((YW'(row_ff) + YW'(1)) == YW'(cfg.height)) &&
                  ((XW'(col_ff) + XW'(1)) == XW'(cfg.width));

   assign nb[0] = win_ff[1][2];
   assign nb[1] = win_ff[1][0];
   assign nb[2] = win_ff[0][1];
   assign nb[3] = win_ff[2][1];
   assign nb[4] = win_ff[0][2];
   assign nb[5] = win_ff[2][2];
   assign nb[6] = win_ff[0][0];
   assign nb[7] = win_ff[2][0];
   assign nb_ok = {bot_ok && right_ok, top_ok && right_ok, bot_ok && left_ok,
                   top_ok && left_ok, bot_ok, top_ok, right_ok, left_ok};

   always_comb begin
      sum_c = '0;
      cnt_c = '0;
      for (int n = 0; n < NEIGHBORS; n++) begin
         if (nb_ok[n] && nb[n].filled && !center.filled) begin
            cnt_c = cnt_c + CNT_BITS'(1);
            for (int ch = 0; ch < CHANNELS; ch++) begin
               sum_c[ch] = sum_c[ch] + SUM_BITS'(nb[n].rgb[ch]);
            end
         end
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      vd_in = adv ? emit : vd_ff;
      if (adv && emit) begin
         if ((XW'(col_ff) + XW'(1)) >= XW'(cfg.width)) begin
            col_in = '0;
            row_in = bot_ok ? row_ff + RB'(1) : '0;
         end else begin
            col_in = col_ff + CB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_d_ff <= sum_c;
         cnt_d_ff <= cnt_c;
         ctr_d_ff <= center;
         end_d_ff <= end_c;
      end
   end

   // reciprocal multiply
   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         prod_in[ch] = PROD_BITS'(sum_d_ff[ch] + SUM_BITS'(cnt_d_ff >> 1)) *
                       PROD_BITS'(RECIP[cnt_d_ff]);
      end
   end

   assign ve_in = adv ? vd_ff : ve_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_e_ff <= prod_in;
         cnt_e_ff <= cnt_d_ff;
         ctr_e_ff <= ctr_d_ff;
         end_e_ff <= end_d_ff;
      end
   end

   always_comb begin
      res_e = ctr_e_ff;
      if (cnt_e_ff != '0) begin
         res_e.filled = 1'b1;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            res_e.rgb[ch] = prod_e_ff[ch][RECIP_SHIFT +: COLOR_BITS];
         end
      end
   end

   // output register
   assign out_v_in = adv ? ve_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         out_px_ff <= res_e;
         out_end_ff <= end_e_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {{(DATA_BITS - PIXEL_BITS){1'b0}}, out_px_ff};
   assign rsp_tlast = out_end_ff;

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         a_ff <= '0;
         fill_ff <= '0;
         vb_ff <= 1'b0;
         fwd_ff <= 1'b0;
         win_ff <= '{default: '0};
         wv_ff <= '0;
         vc_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         a_ff <= a_in;
         fill_ff <= fill_in;
         vb_ff <= vb_in;
         fwd_ff <= fwd_in;
         win_ff <= win_in;
         wv_ff <= wv_in;
         vc_ff <= vc_in;
         col_ff <= col_in;
         row_ff <= row_in;
         vd_ff <= vd_in;
         ve_ff <= ve_in;
         out_v_ff <= out_v_in;
      end
   end

endmodule

>>> tb/gfd_dilation_checker.sv
module gfd_dilation_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [gfd_pkg::DATA_BITS-1:0] req_tdata,    // in_red, in_green, in_blue, in_filled
   input  logic req_tuser,                             // action
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [gfd_pkg::DATA_BITS-1:0] rsp_tdata,    // out_red, out_green, out_blue, out_filled
   input  logic rsp_tlast,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [gfd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gfd_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int outstanding,
   output int mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   import gfd_pkg::*;

   localparam int unsigned LINE_DEPTH = 2048;
   localparam int unsigned ROW_LIMIT = 4096;

   typedef struct packed {
      logic valid;
      logic filled;
      color_type red;
      color_type green;
      color_type blue;
   } pel_type;

   typedef struct packed {
      color_type red;
      color_type green;
      color_type blue;
      logic filled;
      logic frame_end;
   } dilated_type;

   pel_type line_up [LINE_DEPTH];
   pel_type line_mid [LINE_DEPTH];
   pel_type win [3][3];
   logic [WIDTH_BITS-1:0] width_reg;
   logic [HEIGHT_BITS-1:0] height_reg;
   int unsigned in_col, in_row, out_col, out_row, line_addr, in_flight;
   int mismatch_cnt = 0;
   dilated_type dilated_q [$];

   function automatic int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
   endfunction

   function automatic int unsigned active_height();
      if (height_reg == 0) return 1;
      if (height_reg > ROW_LIMIT) return ROW_LIMIT;
      return height_reg;
   endfunction

   function automatic void restart_window();
      for (int i = 0; i < LINE_DEPTH; i++) begin
         line_up[i].valid = 1'b0;
         line_mid[i].valid = 1'b0;
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            win[r][c] = '0;
         end
      end
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      line_addr = 0;
      in_flight = 0;
   endfunction

   // win[stream][age]: stream 0 two lines back, 1 one line back, 2 current
   function automatic void shift_pel(input pel_type incoming, input int unsigned w);
      int unsigned a;
      pel_type up, mid;
      a = (line_addr >= w) ? 0 : line_addr;
      up = line_up[a];
      mid = line_mid[a];
      line_up[a] = mid;
      line_mid[a] = incoming;
      for (int r = 0; r < 3; r++) begin
         win[r][2] = win[r][1];
         win[r][1] = win[r][0];
      end
      win[0][0] = up;
      win[1][0] = mid;
      win[2][0] = incoming;
      line_addr = (a + 1 >= w) ? 0 : a + 1;
   endfunction

   function automatic void dilate_request(input logic action, input pel_type px);
      int unsigned w, h, cnt, sum_r, sum_g, sum_b;
      pel_type incoming, ctr, nb;
      dilated_type res;
      w = active_width();
      h = active_height();
      incoming = px;
      if (action == ACTION_PIXEL) begin
         incoming.valid = 1'b1;
         in_flight++;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) in_row = 0;
         end
      end else begin
         if (in_flight == 0 || in_col != 0 || in_row != 0) return;
         incoming = '0;
      end
      shift_pel(incoming, w);
      ctr = win[1][1];
      if (!ctr.valid) return;
      if (!ctr.filled) begin
         cnt = 0;
         sum_r = 0;
         sum_g = 0;
         sum_b = 0;
         for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
               if (dr == 0 && dc == 0) continue;
               if (dr < 0 && out_row == 0) continue;
               if (dr > 0 && out_row + 1 >= h) continue;
               if (dc < 0 && out_col == 0) continue;
               if (dc > 0 && out_col + 1 >= w) continue;
               nb = win[dr + 1][1 - dc];
               if (!nb.filled) continue;
               sum_r += nb.red;
               sum_g += nb.green;
               sum_b += nb.blue;
               cnt++;
            end
         end
         if (cnt > 0) begin
            ctr.red = color_type'((sum_r + cnt / 2) / cnt);
            ctr.green = color_type'((sum_g + cnt / 2) / cnt);
            ctr.blue = color_type'((sum_b + cnt / 2) / cnt);
            ctr.filled = 1'b1;
         end
      end
      res.red = ctr.red;
      res.green = ctr.green;
      res.blue = ctr.blue;
      res.filled = ctr.filled;
      res.frame_end = (out_row + 1 == h) && (out_col + 1 == w);
      dilated_q = {dilated_q, res};
      in_flight--;
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) out_row = 0;
      end
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         mismatch_cnt++;
         $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      dilated_type want;
      pel_type px;
      if (reset) begin
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         for (int i = 0; i < LINE_DEPTH; i++) begin
            line_up[i] = '0;
            line_mid[i] = '0;
         end
         restart_window();
         dilated_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FRAME_WIDTH) begin
               width_reg = csr_wdata[WIDTH_BITS-1:0];
               restart_window();
            end else if (csr_index == CSR_FRAME_HEIGHT) begin
               height_reg = csr_wdata[HEIGHT_BITS-1:0];
               restart_window();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (dilated_q.size() == 0) begin
               mismatch_cnt++;
               $display("%0t result: expected none, actual %0h last %0b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = dilated_q.pop_front();
               compare_field("out_red", want.red, rsp_tdata[15:0]);
               compare_field("out_green", want.green, rsp_tdata[31:16]);
               compare_field("out_blue", want.blue, rsp_tdata[47:32]);
               compare_field("out_filled", want.filled, rsp_tdata[48]);
               compare_field("frame_end", want.frame_end, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            px.valid = 1'b0;
            px.red = req_tdata[15:0];
            px.green = req_tdata[31:16];
            px.blue = req_tdata[47:32];
            px.filled = req_tdata[48];
            dilate_request(req_tuser, px);
         end
      end
      outstanding <= dilated_q.size();
      mismatches <= mismatch_cnt;
   end

endmodule

>>> tb/tb_gutter_fill_dilation_pass.sv
module tb_gutter_fill_dilation_pass;
   timeunit 1ns;
   timeprecision 1ps;

   import gfd_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 2'd3;
   localparam int IDLE_PCT = 23;
   localparam int NOISE_PCT = 5;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_PIXELS = 1550;
   localparam int unsigned FULL_FRAME = 32'hFFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DATA_BITS-1:0] req_tdata = '0;   // in_red, in_green, in_blue, in_filled
   logic req_tuser = ACTION_PIXEL;         // action
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;        // out_red, out_green, out_blue, out_filled
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int outstanding;
   int mismatches;
   bit calm = 1'b0;
   bit hold_toggle = 1'b0;
   int pixels_sent = 0;

   gutter_fill_dilation_pass i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   gfd_dilation_checker i_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .outstanding(outstanding),
      .mismatches(mismatches)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("[gutter_fill_dilation_pass] ERROR");
      $finish;
   end

   initial begin
      int hold_left;
      bit seen_toggle;
      hold_left = 0;
      seen_toggle = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_toggle != seen_toggle) begin
            seen_toggle = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function automatic color_type rand_color();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return color_type'($urandom);
      endcase
   endfunction

   task automatic push_request(input logic action, input color_type r, g, b,
                               input logic filled);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= action;
      req_tdata <= DATA_BITS'({filled, b, g, r});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic push_drain();
      push_request(ACTION_DRAIN, rand_color(), rand_color(), rand_color(),
                   1'($urandom_range(1)));
   endtask

   task automatic drain_tail(input int unsigned w);
      repeat (w + 1) push_drain();
   endtask

   task automatic send_frame(input int unsigned w, h, fill_pct, stop);
      for (int unsigned i = 0; i < w * h && i < stop; i++) begin
         if ($urandom_range(99) < NOISE_PCT) push_drain();
         push_request(ACTION_PIXEL, rand_color(), rand_color(), rand_color(),
                      $urandom_range(99) < fill_pct);
         pixels_sent++;
      end
   endtask

   task automatic wait_drained(input int settle);
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(input logic [CSR_DATA_BITS-1:0] width_code, height_code);
      write_csr(CSR_FRAME_WIDTH, width_code);
      write_csr(CSR_FRAME_HEIGHT, height_code);
   endtask

   initial begin
      int unsigned w, h, frames, fill, stop, group;
      logic [CSR_DATA_BITS-1:0] w_code, h_code;
      bit partial;

      while (reset) @(posedge clock);

      // 3x3: empty center and three empty corners, filled edges and bottom-right corner with extreme colors
      set_frame(13'd3, 13'd3);
      push_request(ACTION_PIXEL, 16'h1234, 16'h5678, 16'h9abc, 1'b0);
      push_request(ACTION_PIXEL, 16'hffff, 16'hffff, 16'hffff, 1'b1);
      push_request(ACTION_PIXEL, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      push_request(ACTION_PIXEL, 16'h0000, 16'h0001, 16'hffff, 1'b1);
      push_request(ACTION_PIXEL, 16'hffff, 16'h0000, 16'hffff, 1'b0);
      push_request(ACTION_PIXEL, 16'h0001, 16'h0000, 16'h0000, 1'b1);
      push_request(ACTION_PIXEL, 16'hffff, 16'hffff, 16'hffff, 1'b0);
      push_request(ACTION_PIXEL, 16'h8000, 16'h7fff, 16'h0001, 1'b1);
      push_request(ACTION_PIXEL, 16'hffff, 16'h0000, 16'hffff, 1'b1);
      drain_tail(3);
      push_drain();

      // 1x1 back-to-back frames, then spare register indexes
      wait_drained(SETTLE_CYCLES);
      set_frame(13'd1, 13'd1);
      push_request(ACTION_PIXEL, 16'haaaa, 16'h5555, 16'h0000, 1'b0);
      push_request(ACTION_PIXEL, 16'h5555, 16'haaaa, 16'hffff, 1'b1);
      drain_tail(1);
      wait_drained(SETTLE_CYCLES);
      write_csr(CSR_SPARE_LO, 13'h0aaa);
      write_csr(CSR_SPARE_HI, 13'h1fff);
      push_request(ACTION_PIXEL, 16'hffff, 16'h0000, 16'h8000, 1'b1);
      drain_tail(1);

      pixels_sent = 0;
      group = 0;
      while (pixels_sent < RANDOM_PIXELS) begin
         wait_drained(SETTLE_CYCLES);
         calm = (group >= 20 && group < 32);
         if (group == 10) begin
            w = 8;
            h = 8;
         end else begin
            w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            h = $urandom_range(1, 6);
         end
         w_code = (w == 1 && $urandom_range(1)) ? 13'd0 : CSR_DATA_BITS'(w);
         h_code = (h == 1 && $urandom_range(1)) ? 13'd0 : CSR_DATA_BITS'(h);
         if ($urandom_range(7) == 0) w_code[12] = 1'b1;
         if ($urandom_range(1)) begin
            set_frame(w_code, h_code);
         end else begin
            write_csr(CSR_FRAME_HEIGHT, h_code);
            write_csr(CSR_FRAME_WIDTH, w_code);
         end
         frames = (group == 10) ? 3 : $urandom_range(1, 3);
         partial = 1'b0;
         for (int unsigned f = 0; f < frames; f++) begin
            case ($urandom_range(4))
               0: fill = 0;
               1: fill = 20;
               2: fill = 50;
               3: fill = 85;
               default: fill = 100;
            endcase
            if (group == 10 && f == 0) hold_toggle = ~hold_toggle;
            stop = FULL_FRAME;
            if (f == frames - 1 && $urandom_range(3) == 0) begin
               stop = $urandom_range(1, w * h);
               partial = (stop < w * h);
            end
            send_frame(w, h, fill, stop);
            if (group == 15 && f == 0) wait_drained(0);
         end
         if (!partial) drain_tail(w);
         if ($urandom_range(3) == 0) push_drain();
         group++;
      end

      calm = 1'b0;
      wait_drained(SETTLE_CYCLES);
      if (mismatches == 0) begin
         $display("[gutter_fill_dilation_pass] OK");
      end else begin
         $display("[gutter_fill_dilation_pass] ERROR");
      end
      $finish;
   end

endmodule
